// File: hw/rtl/tade_pkg.sv
// ----------------------------------------------------------------------------
// tade_pkg: shared constants and types for the attack/decay envelope block
// Field widths, fixed-point constants, register indexes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tade_pkg;

  // Field widths
  localparam int MAG_W      = 24;   // band magnitude, Q2.22
  localparam int DT_W       = 16;   // time step, 2^-16 s
  localparam int ENV_W      = 17;   // envelope / level, Q0.16 with 1.0 included
  localparam int SPAN_W     = 16;   // attack / decay span
  localparam int TRIG_W     = 17;   // trigger level
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_SPAN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SPAN    = 2'd2;

  // Register reset values
  localparam logic [TRIG_W-1:0] TRIG_RST   = 17'd45875;
  localparam logic [SPAN_W-1:0] ATTACK_RST = 16'd3277;
  localparam logic [SPAN_W-1:0] DECAY_RST  = 16'd32768;

  localparam logic [ENV_W-1:0] ONE_Q16 = 17'd65536;

  // Log unit
  localparam int EXP_W  = 5;              // leading-one position 0..23
  localparam int FRAC_W = 16;             // log2 fraction bits
  localparam int Y_W    = 31;             // mantissa in Q1.30
  localparam int SQ_W   = 2 * Y_W;        // square product
  localparam int LG_W   = EXP_W + FRAC_W + 2;
  localparam int LVP_W  = 45;             // scaled log product / accumulator
  localparam logic signed [LG_W-1:0]  LG_BIAS       = 23'sd1441792;   // 22.0 in Q.16
  localparam logic signed [21:0]      LOG_SCALE_Q24 = 22'sd1683482;   // log10(2)/3
  localparam logic signed [LVP_W-1:0] ACC_BIAS      = 45'sh10000000000; // 1.0 in Q.40

  localparam int SQ_ROUNDS = 16;
  localparam int RND_W     = 4;

  // Restoring divider: (dt << 16) / span
  localparam int DVD_W     = 32;
  localparam int REM_W     = 17;
  localparam int DIV_W     = REM_W + DVD_W;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd32;

  typedef struct packed {
    logic load;        // take a new item
    logic norm_shift;  // shift mantissa left one place
    logic y_load;      // start squaring from the normalized mantissa
    logic sq_mul;      // square the mantissa
    logic sq_upd;      // fold one fraction bit
    logic lv_mul;      // scale the log
    logic lv_add;      // bias, clamp, compare against threshold
    logic div_step;    // one quotient bit in both dividers
    logic env_mul;     // envelope product
    logic env_wr;      // commit envelope and load result register
  } tade_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic skip_log;
  } tade_sts_t;

endpackage

// File: hw/rtl/tade_in_if.sv
// ----------------------------------------------------------------------------
// tade_in_if: input item channel
// Band magnitude, time step and analyzer flag with valid/ready.
// ----------------------------------------------------------------------------
interface tade_in_if;
  import tade_pkg::*;

  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] band_magnitude;
  logic [DT_W-1:0]  time_step;
  logic             analyzer_ok;

  modport source (output valid, output band_magnitude, output time_step,
                  output analyzer_ok, input ready);
  modport sink   (input valid, input band_magnitude, input time_step,
                  input analyzer_ok, output ready);
endinterface

// File: hw/rtl/tade_out_if.sv
// ----------------------------------------------------------------------------
// tade_out_if: result channel
// Envelope value with valid/ready.
// ----------------------------------------------------------------------------
interface tade_out_if;
  import tade_pkg::*;

  logic             valid;
  logic             ready;
  logic [ENV_W-1:0] envelope_out;

  modport source (output valid, output envelope_out, input ready);
  modport sink   (input valid, input envelope_out, output ready);
endinterface

// File: hw/rtl/tade_cfg_if.sv
// ----------------------------------------------------------------------------
// tade_cfg_if: configuration write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface tade_cfg_if;
  import tade_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/tade_dp.sv
// ----------------------------------------------------------------------------
// tade_dp: envelope datapath
// Configuration registers, log2 unit (normalize + repeated squaring), level
// scaling, two restoring dividers and the envelope multiply.
// ----------------------------------------------------------------------------
module tade_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tade_pkg::tade_cmd_t             cmd,
  output tade_pkg::tade_sts_t             sts,
  input  logic [tade_pkg::MAG_W-1:0]      in_mag,
  input  logic [tade_pkg::DT_W-1:0]       in_dt,
  input  logic                            in_ok,
  input  logic                            cfg_we,
  input  logic [tade_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tade_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [tade_pkg::ENV_W-1:0]      out_env
);
  import tade_pkg::*;

  // One restoring step: remainder in the top field, dividend bits leave
  // the top of the low field while quotient bits enter at the bottom.
  function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] st,
                                                input logic [SPAN_W-1:0] dv);
    logic [REM_W-1:0] rs;
    logic [DIV_W-1:0] res;
    rs = {st[DVD_W+REM_W-2:DVD_W], st[DVD_W-1]};
    if (rs >= {1'b0, dv}) begin
      res = {rs - {1'b0, dv}, st[DVD_W-2:0], 1'b1};
    end else begin
      res = {rs, st[DVD_W-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [ENV_W-1:0] frac_clamp(input logic [DVD_W-1:0] q);
    logic [ENV_W-1:0] f;
    if (q > DVD_W'(ONE_Q16)) begin
      f = ONE_Q16;
    end else begin
      f = q[ENV_W-1:0];
    end
    return f;
  endfunction

  logic [TRIG_W-1:0]       trig_r;
  logic [SPAN_W-1:0]       atk_span_r;
  logic [SPAN_W-1:0]       dcy_span_r;
  logic                    ok_r;
  logic [MAG_W-1:0]        mant_r;
  logic [EXP_W-1:0]        exp_r;
  logic [Y_W-1:0]          y_r;
  logic [SQ_W-1:0]         sq_prod_r;
  logic [FRAC_W-1:0]       frac_r;
  logic signed [LVP_W-1:0] lv_prod_r;
  logic                    attack_r;
  logic [DIV_W-1:0]        atk_div_r;
  logic [DIV_W-1:0]        dcy_div_r;
  logic [2*ENV_W-1:0]      env_prod_r;
  logic [ENV_W-1:0]        env_r;
  logic [ENV_W-1:0]        out_env_r;

  logic [DVD_W-1:0]        sq_top;
  logic signed [LG_W-1:0]  lg_w;
  logic signed [LVP_W-1:0] acc_w;
  logic [LVP_W-25:0]       lvq_w;
  logic [ENV_W-1:0]        lv_w;
  logic [ENV_W-1:0]        f_sel;
  logic [ENV_W-1:0]        a_op;
  logic [ENV_W-1:0]        b_op;
  logic [ENV_W-1:0]        p_w;
  logic [ENV_W-1:0]        env_new;

  always_comb begin
    sq_top = sq_prod_r[SQ_W-1:Y_W-1];
    lg_w   = signed'({2'b00, exp_r, frac_r}) - LG_BIAS;
    acc_w  = lv_prod_r + ACC_BIAS;
    lvq_w  = acc_w[LVP_W-1:24];
    if (acc_w <= 0) begin
      lv_w = '0;
    end else if (lvq_w > (LVP_W-24)'(ONE_Q16)) begin
      lv_w = ONE_Q16;
    end else begin
      lv_w = lvq_w[ENV_W-1:0];
    end
    f_sel   = attack_r ? frac_clamp(atk_div_r[DVD_W-1:0]) : frac_clamp(dcy_div_r[DVD_W-1:0]);
    a_op    = attack_r ? (ONE_Q16 - env_r) : env_r;
    b_op    = ONE_Q16 - f_sel;
    p_w     = env_prod_r[ENV_W+15:16];
    env_new = attack_r ? (ONE_Q16 - p_w) : p_w;
  end

  assign sts.norm_done = mant_r[MAG_W-1] || (exp_r == '0);
  assign sts.skip_log  = !ok_r || (mant_r == '0);
  assign out_env       = out_env_r;

  // Configuration and envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r     <= TRIG_RST;
      atk_span_r <= ATTACK_RST;
      dcy_span_r <= DECAY_RST;
      env_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TRIGGER_LEVEL: trig_r     <= cfg_data[TRIG_W-1:0];
          CFG_ATTACK_SPAN:   atk_span_r <= cfg_data[SPAN_W-1:0];
          CFG_DECAY_SPAN:    dcy_span_r <= cfg_data[SPAN_W-1:0];
          default: ;  // drop writes past the register list
        endcase
      end
      if (cmd.env_wr) begin
        env_r <= env_new;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok_r      <= in_ok;
      mant_r    <= in_mag;
      exp_r     <= EXP_W'(MAG_W - 1);
      attack_r  <= 1'b0;
      atk_div_r <= {{REM_W{1'b0}}, in_dt, {(DVD_W-DT_W){1'b0}}};
      dcy_div_r <= {{REM_W{1'b0}}, in_dt, {(DVD_W-DT_W){1'b0}}};
    end else begin
      if (cmd.norm_shift) begin
        mant_r <= {mant_r[MAG_W-2:0], 1'b0};
        exp_r  <= exp_r - 1'b1;
      end
      if (cmd.div_step) begin
        atk_div_r <= div_step(atk_div_r, atk_span_r);
        dcy_div_r <= div_step(dcy_div_r, dcy_span_r);
      end
      if (cmd.lv_add) begin
        attack_r <= (lv_w >= trig_r) && (lv_w > env_r);
      end
    end
    if (cmd.y_load) begin
      y_r    <= {mant_r, {(Y_W-MAG_W){1'b0}}};
      frac_r <= '0;
    end
    if (cmd.sq_mul) begin
      sq_prod_r <= y_r * y_r;
    end
    if (cmd.sq_upd) begin
      if (sq_top[DVD_W-1]) begin
        y_r    <= sq_top[DVD_W-1:1];
        frac_r <= {frac_r[FRAC_W-2:0], 1'b1};
      end else begin
        y_r    <= sq_top[Y_W-1:0];
        frac_r <= {frac_r[FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.lv_mul) begin
      lv_prod_r <= lg_w * LOG_SCALE_Q24;
    end
    if (cmd.env_mul) begin
      env_prod_r <= a_op * b_op;
    end
    if (cmd.env_wr) begin
      out_env_r <= env_new;
    end
  end

`ifndef SYNTHESIS
  a_env_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= ONE_Q16)
    else $error("envelope above 1.0");
`endif

endmodule

// File: hw/rtl/tade_ctrl.sv
// ----------------------------------------------------------------------------
// tade_ctrl: envelope controller
// Sequences normalize, squaring rounds, level scaling, divider and envelope
// update; owns the result valid flag.
// ----------------------------------------------------------------------------
module tade_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  tade_pkg::tade_sts_t sts,
  output tade_pkg::tade_cmd_t cmd
);
  import tade_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQ_MUL, S_SQ_UPD, S_LV_MUL, S_LV_ADD,
    S_DIV_WAIT, S_ENV_MUL, S_ENV_WR
  } state_t;

  state_t               state_r, state_nxt;
  logic [RND_W-1:0]     rnd_r, rnd_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    div_cnt_nxt   = (div_cnt_r != '0) ? div_cnt_r - 1'b1 : div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.div_step  = (div_cnt_r != '0);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          div_cnt_nxt = DIV_STEPS;
          state_nxt   = S_NORM;
        end
      end
      S_NORM: begin
        priority if (sts.skip_log) begin
          state_nxt = S_DIV_WAIT;
        end else if (sts.norm_done) begin
          cmd.y_load = 1'b1;
          rnd_nxt    = '0;
          state_nxt  = S_SQ_MUL;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      S_SQ_MUL: begin
        cmd.sq_mul = 1'b1;
        state_nxt  = S_SQ_UPD;
      end
      S_SQ_UPD: begin
        cmd.sq_upd = 1'b1;
        rnd_nxt    = rnd_r + 1'b1;
        state_nxt  = (rnd_r == RND_W'(SQ_ROUNDS - 1)) ? S_LV_MUL : S_SQ_MUL;
      end
      S_LV_MUL: begin
        cmd.lv_mul = 1'b1;
        state_nxt  = S_LV_ADD;
      end
      S_LV_ADD: begin
        cmd.lv_add = 1'b1;
        state_nxt  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_cnt_r == '0) begin
          state_nxt = S_ENV_MUL;
        end
      end
      S_ENV_MUL: begin
        cmd.env_mul = 1'b1;
        state_nxt   = S_ENV_WR;
      end
      S_ENV_WR: begin
        if (!out_valid_r || out_ready) begin
          cmd.env_wr    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd_r       <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENV_MUL) |-> (div_cnt_r == '0))
    else $error("envelope update before divider finished");
`endif
`ifndef SYNTHESIS
  a_all_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LV_MUL) |-> ($past(state_r) == S_SQ_UPD && rnd_r == '0))
    else $error("level scaling started before all squaring rounds");
`endif
`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENV_WR && out_valid_r && !out_ready) |=>
      (state_r == S_ENV_WR && out_valid_r))
    else $error("result register overwritten before transfer");
`endif

endmodule

// File: hw/rtl/transient_attack_decay_envelope.sv
// ----------------------------------------------------------------------------
// transient_attack_decay_envelope: attack/decay envelope follower
// Turns a band magnitude into a dB-normalized level and moves a Q0.16
// envelope toward 1.0 (attack) or 0 (decay) by a time-step fraction.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake      Payload
//  in_ch     in    valid/ready    band_magnitude[23:0], time_step[15:0],
//                                 analyzer_ok
//  out_ch    out   valid/ready    envelope_out[16:0]
//  cfg_ch    in    valid/ready    index[1:0], data[16:0]
//
//  One item at a time. The log is skipped when the analyzer is not valid or
//  the magnitude is zero; otherwise the time to a result is set by the
//  one-bit-per-cycle normalize shift (23 minus the magnitude's leading-one
//  position) and 16 squaring rounds (multiply, then update) of the log2 unit.
//  Both 32-step dividers run alongside the log and never add cycles there.
//  in_ch.ready is high in idle, also while a result waits in the output
//  register; a finished item holds until that register is free.
//  cfg_ch is always ready. Reset (rst_n low, synchronous) restores register
//  defaults and clears the envelope.
// ----------------------------------------------------------------------------
module transient_attack_decay_envelope (
  input  logic         clk,
  input  logic         rst_n,
  tade_in_if.sink      in_ch,
  tade_out_if.source   out_ch,
  tade_cfg_if.sink     cfg_ch
);
  import tade_pkg::*;

  tade_cmd_t        cmd;
  tade_sts_t        sts;
  logic             in_ready;
  logic             out_valid;
  logic [ENV_W-1:0] out_env;

  // Configuration writes go straight into their registers, so never back-pressure them.
  assign cfg_ch.ready = 1'b1;

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.envelope_out = out_env;

  // Controller: walks normalize -> square rounds -> level -> divider wait -> envelope
  // (the log steps are passed over when the log is skipped), and holds the result until its transfer.
  tade_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: captures the item on cmd.load, and keeps configuration and
  // envelope state.
  tade_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_mag   (in_ch.band_magnitude),
    .in_dt    (in_ch.time_step),
    .in_ok    (in_ch.analyzer_ok),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .out_env  (out_env)
  );

endmodule
